@@ hdl/assert_macros.svh @@
// Assertion helpers for the timer queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DTQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtq check failed");
`define DTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtq check failed");
`else
`define DTQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/dtq_pkg.sv @@
`default_nettype none
package dtq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int TIME_BITS_DEF = 32;
    localparam int MAX_RES       = 16;
    localparam int FIRE_CNT_W    = $clog2(MAX_RES);

    typedef enum logic [1:0] {
        ACT_ARM    = 2'd0,
        ACT_CANCEL = 2'd1,
        ACT_TICK   = 2'd2,
        ACT_UNDEF  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        K_DONE      = 3'd0,
        K_NOT_FOUND = 3'd1,
        K_FIRED     = 3'd2,
        K_NOTHING   = 3'd3,
        K_ERROR     = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  timer_id;
        logic [31:0] time_value;
    } dtq_req_t;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [3:0]  fired_id;
        logic [31:0] fired_deadline;
        logic        last_of_run;
        logic [31:0] next_deadline;
        logic        queue_empty;
    } dtq_rsp_t;

endpackage
`default_nettype wire

@@ hdl/deadline_timer_queue_core.sv @@
// Arm, cancel or bad request: one scan of the deadline RAM, then the result word.
// Tick with nothing due: one scan, then one word.
// Tick firing k timers: k words, each after a rescan of the deadline RAM.
// The next request is taken in the cycle after the last word is loaded; no new request
// is taken while one is in progress, and output stalls hold the block in its emit state.
// The scan walks the deadline RAM one slot per cycle through a single shared comparator.
// Reset (async, active low) disarms all timers; deadline RAM contents are not cleared.
`default_nettype none
`include "assert_macros.svh"
module deadline_timer_queue_core
    import dtq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire dtq_req_t req_word,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output dtq_rsp_t      rsp_word
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    state_t                state_reg, state_next;
    logic [DEPTH-1:0]      armed_reg, armed_next;
    logic [CNT_W-1:0]      scan_cnt_reg, scan_cnt_next;
    logic                  rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                  best_found_reg, best_found_next;
    logic [IDX_W-1:0]      best_id_reg, best_id_next;
    logic [TIME_BITS-1:0]  best_dl_reg, best_dl_next;
    logic [IDX_W-1:0]      cur_id_reg, cur_id_next;
    logic [TIME_BITS-1:0]  cur_dl_reg, cur_dl_next;
    logic                  tick_reg, tick_next;
    logic                  fire_mode_reg, fire_mode_next;
    logic [FIRE_CNT_W-1:0] fire_cnt_reg, fire_cnt_next;
    logic [TIME_BITS-1:0]  tv_reg, tv_next;
    kind_t                 kind_reg, kind_next;
    logic                  out_valid_reg, out_valid_next;
    dtq_rsp_t              out_word_reg, out_word_next;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_raddr;
    logic [TIME_BITS-1:0]  ram_rdata;
    logic [IDX_W-1:0]      req_idx;
    logic                  id_ok;
    logic [TIME_BITS-1:0]  cmp_a;
    logic                  cmp_lt;
    logic                  scan_done;
    logic                  out_free;
    logic                  last_res;
    dtq_rsp_t              res;

    assign req_idx   = IDX_W'(req_word.timer_id);
    assign id_ok     = 32'(req_word.timer_id) < 32'(DEPTH);
    // shared comparator: slot vs best while scanning, tick time vs best otherwise
    assign cmp_a     = rd_pend_reg ? ram_rdata : tv_reg;
    assign cmp_lt    = cmp_a < best_dl_reg;
    assign scan_done = (scan_cnt_reg == CNT_W'(DEPTH)) && !rd_pend_reg;
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_word_reg;

    dtq_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (DEPTH)
    ) u_dl_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (req_idx),
        .wdata (TIME_BITS'(req_word.time_value)),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        last_res = !(tick_reg && fire_mode_reg) ||
                   (fire_cnt_reg == FIRE_CNT_W'(MAX_RES - 1)) ||
                   !best_found_reg || cmp_lt;
        res.result_kind    = kind_reg;
        res.fired_id       = '0;
        res.fired_deadline = '0;
        res.last_of_run    = last_res;
        res.next_deadline  = best_found_reg ? 32'(best_dl_reg) : 32'd0;
        res.queue_empty    = !best_found_reg;
        if (tick_reg)
        begin
            if (fire_mode_reg)
            begin
                res.result_kind    = K_FIRED;
                res.fired_id       = 4'(cur_id_reg);
                res.fired_deadline = 32'(cur_dl_reg);
            end
            else
            begin
                res.result_kind = K_NOTHING;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        armed_next      = armed_reg;
        scan_cnt_next   = scan_cnt_reg;
        rd_pend_next    = 1'b0;
        rd_idx_next     = rd_idx_reg;
        best_found_next = best_found_reg;
        best_id_next    = best_id_reg;
        best_dl_next    = best_dl_reg;
        cur_id_next     = cur_id_reg;
        cur_dl_next     = cur_dl_reg;
        tick_next       = tick_reg;
        fire_mode_next  = fire_mode_reg;
        fire_cnt_next   = fire_cnt_reg;
        tv_next         = tv_reg;
        kind_next       = kind_reg;
        out_valid_next  = out_valid_reg && rsp_stall;
        out_word_next   = out_word_reg;
        ram_we          = 1'b0;
        ram_raddr       = scan_cnt_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    tick_next       = (req_word.action == ACT_TICK);
                    tv_next         = TIME_BITS'(req_word.time_value);
                    scan_cnt_next   = '0;
                    best_found_next = 1'b0;
                    fire_mode_next  = 1'b0;
                    fire_cnt_next   = '0;
                    kind_next       = K_ERROR;
                    state_next      = ST_SCAN;
                    if (req_word.action == ACT_ARM && id_ok)
                    begin
                        ram_we              = 1'b1;
                        armed_next[req_idx] = 1'b1;
                        kind_next           = K_DONE;
                    end
                    else if (req_word.action == ACT_CANCEL && id_ok)
                    begin
                        if (armed_reg[req_idx])
                        begin
                            armed_next[req_idx] = 1'b0;
                            kind_next           = K_DONE;
                        end
                        else
                        begin
                            kind_next = K_NOT_FOUND;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                if (scan_cnt_reg < CNT_W'(DEPTH))
                begin
                    rd_pend_next  = 1'b1;
                    rd_idx_next   = scan_cnt_reg[IDX_W-1:0];
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                if (rd_pend_reg && armed_reg[rd_idx_reg] && (!best_found_reg || cmp_lt))
                begin
                    best_found_next = 1'b1;
                    best_id_next    = rd_idx_reg;
                    best_dl_next    = ram_rdata;
                end
                if (scan_done)
                begin
                    if (tick_reg && !fire_mode_reg && best_found_reg && !cmp_lt)
                    begin
                        cur_id_next              = best_id_reg;
                        cur_dl_next              = best_dl_reg;
                        armed_next[best_id_reg]  = 1'b0;
                        fire_mode_next           = 1'b1;
                        scan_cnt_next            = '0;
                        best_found_next          = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = res;
                    if (!last_res)
                    begin
                        cur_id_next             = best_id_reg;
                        cur_dl_next             = best_dl_reg;
                        armed_next[best_id_reg] = 1'b0;
                        fire_cnt_next           = fire_cnt_reg + 1'b1;
                        scan_cnt_next           = '0;
                        best_found_next         = 1'b0;
                        state_next              = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            armed_reg      <= '0;
            scan_cnt_reg   <= '0;
            rd_pend_reg    <= 1'b0;
            best_found_reg <= 1'b0;
            tick_reg       <= 1'b0;
            fire_mode_reg  <= 1'b0;
            fire_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            armed_reg      <= armed_next;
            scan_cnt_reg   <= scan_cnt_next;
            rd_pend_reg    <= rd_pend_next;
            best_found_reg <= best_found_next;
            tick_reg       <= tick_next;
            fire_mode_reg  <= fire_mode_next;
            fire_cnt_reg   <= fire_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        best_id_reg  <= best_id_next;
        best_dl_reg  <= best_dl_next;
        cur_id_reg   <= cur_id_next;
        cur_dl_reg   <= cur_dl_next;
        tv_reg       <= tv_next;
        kind_reg     <= kind_next;
        out_word_reg <= out_word_next;
    end

    `DTQ_ASSERT_IMPL(a_notlast_is_fire, clk, rst_n, rsp_valid && !rsp_word.last_of_run, rsp_word.result_kind == K_FIRED)
    `DTQ_ASSERT_IMPL(a_fire_is_due, clk, rst_n, state_reg == ST_EMIT && tick_reg && fire_mode_reg, !(tv_reg < cur_dl_reg))
    `DTQ_ASSERT_IMPL(a_fired_disarmed, clk, rst_n, state_reg == ST_EMIT && tick_reg && fire_mode_reg, !armed_reg[cur_id_reg])
    `DTQ_ASSERT_NEXT(a_arm_sets, clk, rst_n, req_valid && !req_stall && req_word.action == ACT_ARM && id_ok, armed_reg[$past(req_idx)])

endmodule
`default_nettype wire

@@ hdl/dtq_ram.sv @@
`default_nettype none
module dtq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire
